### design/ccmd_pkg.sv
package ccmd_pkg;

   // Line state codes
   localparam logic [2:0] ST_I  = 3'd0;
   localparam logic [2:0] ST_S  = 3'd1;
   localparam logic [2:0] ST_E  = 3'd2;
   localparam logic [2:0] ST_SC = 3'd3;
   localparam logic [2:0] ST_SM = 3'd4;
   localparam logic [2:0] ST_M  = 3'd5;

   // Bus transaction codes
   localparam logic [1:0] BUS_NONE = 2'd0;
   localparam logic [1:0] BUS_RD   = 2'd1;
   localparam logic [1:0] BUS_RDX  = 2'd2;
   localparam logic [1:0] BUS_UPD  = 2'd3;

   // Request kinds
   localparam logic [2:0] RQ_READ   = 3'd0;
   localparam logic [2:0] RQ_WRITE  = 3'd1;
   localparam logic [2:0] RQ_BUSRD  = 3'd2;
   localparam logic [2:0] RQ_BUSRDX = 3'd3;
   localparam logic [2:0] RQ_BUSUPD = 3'd4;
   localparam logic [2:0] RQ_DONE   = 3'd5;

   // Pending Dragon transaction kinds
   localparam logic [1:0] PEND_NONE     = 2'd0;
   localparam logic [1:0] PEND_RD_MISS  = 2'd1;
   localparam logic [1:0] PEND_WR_MISS  = 2'd2;
   localparam logic [1:0] PEND_WR_HIT   = 2'd3;

   localparam logic MODE_MSI    = 1'b0;
   localparam logic MODE_DRAGON = 1'b1;

   localparam int STAMP_W = 32;
   localparam int LSTATE_W = 3;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] address;
      logic        copy_exist;
   } req_item_type;

   typedef struct packed {
      logic [1:0] bus_request;
      logic       hit;
      logic       victim_writeback;
      logic       snoop_flush;
      logic       shared_copy;
      logic [2:0] new_state;
   } rsp_item_type;

   typedef enum logic [1:0] {
      CTL_CLEAR,
      CTL_IDLE,
      CTL_LOOKUP
   } ctl_state_type;

   typedef struct packed {
      logic accept;
      logic commit;
      logic clear_wr;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rsp_busy;
   } ctl_status_type;

endpackage

### design/ccmd_ram.sv
module ccmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/ccmd_ctrl.sv
module ccmd_ctrl
   import ccmd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic           rsp_stall,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_CLEAR: begin
            if (status.clear_last) state_in = CTL_IDLE;
         end
         CTL_IDLE: begin
            if (req_valid) state_in = CTL_LOOKUP;
         end
         CTL_LOOKUP: begin
            if (!status.rsp_busy || !rsp_stall) state_in = CTL_IDLE;
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         CTL_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         CTL_IDLE: begin
            req_stall = 1'b0;
            cmd.accept = req_valid;
         end
         CTL_LOOKUP: begin
            cmd.commit = !status.rsp_busy || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == CTL_LOOKUP)
      else $error("accepted beat did not enter lookup");

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(status.rsp_busy && rsp_stall))
      else $error("commit while result slot is stalled");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_wr |-> !cmd.accept && !cmd.commit)
      else $error("beat handled during clearing pass");

endmodule

### design/ccmd_dp.sv
module ccmd_dp
   import ccmd_pkg::*;
#(
   parameter int SETS = 64,
   parameter int WAYS = 4,
   parameter int LINE_BYTES = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  ctl_cmd_type    cmd,
   output ctl_status_type status,
   input  req_item_type   req_data,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_item_type   rsp_data,
   input  logic           csr_wr_en,
   input  logic           csr_wr_data
);

   localparam int OFF_W  = $clog2(LINE_BYTES);
   localparam int SET_W  = $clog2(SETS);
   localparam int SET_IW = SET_W > 0 ? SET_W : 1;
   localparam int TAG_W  = 32 - OFF_W - SET_W;
   localparam int WAY_IW = WAYS > 1 ? $clog2(WAYS) : 1;
   localparam int SS_W   = LSTATE_W + STAMP_W;

   req_item_type        req_ff;
   logic [SET_IW-1:0]   set_ff, set_in;
   logic [SET_IW-1:0]   clr_cnt_ff;
   logic [STAMP_W-1:0]  clock_ff, clock_in;
   logic [1:0]          pend_ff, pend_in;
   logic                mode_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_ff, rsp_in;

   logic [WAYS*TAG_W-1:0] tag_row_rd, tag_row_wr;
   logic [WAYS*SS_W-1:0]  ss_row_rd, ss_row_wr, ss_wdata;
   logic                  tag_we, ss_we;
   logic [SET_IW-1:0]     ss_waddr;

   logic [31:0]         blk_in;
   logic [TAG_W-1:0]    tag_cur;
   logic [TAG_W-1:0]    way_tag   [WAYS];
   logic [2:0]          way_st    [WAYS];
   logic [STAMP_W-1:0]  way_stamp [WAYS];
   logic [2:0]          new_st    [WAYS];
   logic [STAMP_W-1:0]  new_stamp [WAYS];
   logic [TAG_W-1:0]    new_tag   [WAYS];
   logic                found, inv_found, lru_found;
   logic [WAY_IW-1:0]   hit_way, inv_way, lru_way, idx;
   logic [STAMP_W-1:0]  least;
   logic [2:0]          s;

   // Set index of the incoming beat and tag of the registered beat
   assign blk_in = req_data.address >> OFF_W;
   assign set_in = (SETS == 1) ? '0 : SET_IW'(blk_in);
   assign tag_cur = TAG_W'((req_ff.address >> OFF_W) >> SET_W);

   ccmd_ram #(.WIDTH(WAYS*TAG_W), .DEPTH(SETS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (set_ff),
      .wr_data (tag_row_wr),
      .rd_en   (cmd.accept),
      .rd_addr (set_in),
      .rd_data (tag_row_rd)
   );

   ccmd_ram #(.WIDTH(WAYS*SS_W), .DEPTH(SETS)) u_ss_ram (
      .clock   (clock),
      .wr_en   (ss_we),
      .wr_addr (ss_waddr),
      .wr_data (ss_wdata),
      .rd_en   (cmd.accept),
      .rd_addr (set_in),
      .rd_data (ss_row_rd)
   );

   // Unpack the set's ways
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         way_tag[w]   = tag_row_rd[w*TAG_W +: TAG_W];
         way_st[w]    = ss_row_rd[w*SS_W + STAMP_W +: LSTATE_W];
         way_stamp[w] = ss_row_rd[w*SS_W +: STAMP_W];
      end
   end

   // Lookup, victim choice and protocol update
   always_comb begin
      found = 1'b0;
      hit_way = '0;
      inv_found = 1'b0;
      inv_way = '0;
      lru_found = 1'b0;
      lru_way = '0;
      clock_in = clock_ff + 1'b1;
      least = clock_in;
      pend_in = pend_ff;
      rsp_in = '0;
      tag_we = 1'b0;
      s = ST_I;
      for (int w = 0; w < WAYS; w++) begin
         new_st[w] = way_st[w];
         new_stamp[w] = way_stamp[w];
         new_tag[w] = way_tag[w];
      end
      for (int w = 0; w < WAYS; w++) begin
         if (!found && way_st[w] != ST_I && way_tag[w] == tag_cur) begin
            found = 1'b1;
            hit_way = WAY_IW'(w);
         end
         if (!inv_found && way_st[w] == ST_I) begin
            inv_found = 1'b1;
            inv_way = WAY_IW'(w);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         if (way_stamp[w] <= least) begin
            lru_found = 1'b1;
            lru_way = WAY_IW'(w);
            least = way_stamp[w];
         end
      end
      idx = hit_way;
      if (req_ff.req_type == RQ_READ || req_ff.req_type == RQ_WRITE) begin
         pend_in = PEND_NONE;
         rsp_in.hit = found;
         if (!found) begin
            idx = inv_found ? inv_way : (lru_found ? lru_way : '0);
            rsp_in.victim_writeback = (way_st[idx] == ST_M) || (way_st[idx] == ST_SM);
            new_tag[idx] = tag_cur;
            tag_we = cmd.commit;
            if (req_ff.req_type == RQ_WRITE) begin
               new_st[idx] = ST_M;
               if (mode_ff == MODE_MSI) begin
                  rsp_in.bus_request = BUS_RDX;
               end else begin
                  rsp_in.bus_request = BUS_RD;
                  pend_in = PEND_WR_MISS;
               end
            end else begin
               rsp_in.bus_request = BUS_RD;
               if (mode_ff == MODE_MSI) begin
                  new_st[idx] = ST_S;
               end else begin
                  new_st[idx] = ST_SC;
                  pend_in = PEND_RD_MISS;
               end
            end
         end else if (req_ff.req_type == RQ_WRITE) begin
            s = way_st[idx];
            if (mode_ff == MODE_MSI) begin
               if (s == ST_S) new_st[idx] = ST_M;
            end else begin
               pend_in = PEND_WR_HIT;
               if (s == ST_SC || s == ST_SM) rsp_in.bus_request = BUS_UPD;
               else if (s == ST_E) new_st[idx] = ST_M;
            end
         end
         new_stamp[idx] = clock_in;
         rsp_in.new_state = new_st[idx];
      end else if (req_ff.req_type == RQ_BUSRD || req_ff.req_type == RQ_BUSRDX ||
                   req_ff.req_type == RQ_BUSUPD) begin
         clock_in = clock_ff;
         rsp_in.hit = found;
         if (found) begin
            s = way_st[idx];
            if (mode_ff == MODE_MSI) begin
               if (s == ST_M) begin
                  new_st[idx] = ST_I;
                  rsp_in.snoop_flush = 1'b1;
               end else if (s == ST_S) begin
                  new_st[idx] = ST_I;
               end
            end else if (req_ff.req_type == RQ_BUSRD) begin
               rsp_in.shared_copy = 1'b1;
               if (s == ST_E) begin
                  new_st[idx] = ST_SC;
               end else if (s == ST_M) begin
                  new_st[idx] = ST_SM;
                  rsp_in.snoop_flush = 1'b1;
               end else if (s == ST_SM) begin
                  rsp_in.snoop_flush = 1'b1;
               end
            end else if (req_ff.req_type == RQ_BUSUPD) begin
               rsp_in.shared_copy = 1'b1;
               if (s == ST_SM) new_st[idx] = ST_SC;
            end
            rsp_in.new_state = new_st[idx];
         end
      end else if (req_ff.req_type == RQ_DONE) begin
         clock_in = clock_ff;
         rsp_in.hit = found;
         if (found) begin
            s = way_st[idx];
            if (mode_ff == MODE_DRAGON) begin
               priority case (pend_ff)
                  PEND_WR_MISS: begin
                     if (req_ff.copy_exist) begin
                        new_st[idx] = ST_SM;
                        rsp_in.bus_request = BUS_UPD;
                     end else begin
                        new_st[idx] = ST_M;
                     end
                  end
                  PEND_RD_MISS: new_st[idx] = req_ff.copy_exist ? ST_SC : ST_E;
                  PEND_WR_HIT: begin
                     if (s == ST_E) new_st[idx] = ST_M;
                     else if (s == ST_SC) new_st[idx] = req_ff.copy_exist ? ST_SM : ST_M;
                     else if (s == ST_SM && !req_ff.copy_exist) new_st[idx] = ST_M;
                  end
                  default: new_st[idx] = s;
               endcase
            end
            rsp_in.new_state = new_st[idx];
         end
      end else begin
         clock_in = clock_ff;
      end
   end

   // Repack the set rows
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         tag_row_wr[w*TAG_W +: TAG_W] = new_tag[w];
         ss_row_wr[w*SS_W +: SS_W] = {new_st[w], new_stamp[w]};
      end
   end

   // Clearing pass writes zero rows, lookups write the updated row
   assign ss_we    = cmd.clear_wr || cmd.commit;
   assign ss_waddr = cmd.clear_wr ? clr_cnt_ff : set_ff;
   assign ss_wdata = cmd.clear_wr ? '0 : ss_row_wr;

   assign status.clear_last = (clr_cnt_ff == SET_IW'(SETS - 1));
   assign status.rsp_busy   = rsp_valid_ff;

   // Hold or release the result slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         clock_ff <= '0;
         pend_ff <= PEND_NONE;
         mode_ff <= MODE_MSI;
         clr_cnt_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            clock_ff <= clock_in;
            pend_ff <= pend_in;
         end
         if (csr_wr_en) mode_ff <= csr_wr_data;
         if (cmd.clear_wr) clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // Capture the beat and the result
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
         set_ff <= set_in;
      end
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_state_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.new_state <= ST_M)
      else $error("result carries an unknown line state");

   a_flush_is_snoop: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && rsp_in.snoop_flush |-> rsp_in.hit && rsp_in.bus_request == BUS_NONE)
      else $error("flush without snooped hit");

   a_victim_is_miss: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && rsp_in.victim_writeback |-> !rsp_in.hit)
      else $error("victim writeback on a hit");

endmodule

### design/coherent_cache_controller_msi_dragon_core.sv
// A beat accepted in the idle state reads its set row from the tag and state
// memories into registers. Its lookup commits, registers the result and
// writes the row back once the result slot is empty or not stalled; no new
// beat is taken before that. Reset: synchronous; a clearing pass zeroes line
// states and stamps row by row, taking no beats meanwhile. Tags are not cleared.
module coherent_cache_controller_msi_dragon_core
   import ccmd_pkg::*;
#(
   parameter int SETS = 64,
   parameter int WAYS = 4,
   parameter int LINE_BYTES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   ccmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ccmd_dp #(.SETS(SETS), .WAYS(WAYS), .LINE_BYTES(LINE_BYTES)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ccmd_pkg::*;

   localparam int SETS = 64;
   localparam int WAYS = 4;
   localparam int LINE_BYTES = 64;
   localparam int NLINES = SETS * WAYS;
   localparam int CYCLE_LIMIT = 400000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_data;
   logic         csr_wr_en;
   logic         csr_wr_data;

   // cache image kept by the predictor
   logic [31:0] cache_tag [NLINES];
   logic [2:0]  cache_state [NLINES];
   logic [31:0] cache_stamp [NLINES];
   logic [31:0] touch_count;
   logic [1:0]  open_kind;
   logic        mode_dragon;

   rsp_item_type expected_rsp [$];
   int          error_count = 0;
   int          cycle_count = 0;
   logic        stall_enable;

   coherent_cache_controller_msi_dragon_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // pick the way to refill: first invalid, else oldest stamp (last on tie)
   function automatic int choose_victim(int base);
      int          victim;
      logic [31:0] least;
      victim = WAYS;
      least = touch_count;
      for (int w = 0; w < WAYS; w++) begin
         if (cache_state[base + w] == ST_I) return base + w;
      end
      for (int w = 0; w < WAYS; w++) begin
         if (cache_stamp[base + w] <= least) begin
            victim = w;
            least = cache_stamp[base + w];
         end
      end
      if (victim >= WAYS) victim = 0;
      return base + victim;
   endfunction

   // advance the cache image by one beat and return the response it gives
   function automatic rsp_item_type predict_coherence(req_item_type rq);
      rsp_item_type r;
      logic [31:0]  blk, tag;
      int           base, idx;
      logic         found;
      logic [2:0]   s;
      r = '0;
      blk = rq.address / LINE_BYTES;
      tag = blk / SETS;
      base = int'(blk % SETS) * WAYS;
      idx = 0;
      found = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && cache_state[base + w] != ST_I && cache_tag[base + w] == tag) begin
            idx = base + w;
            found = 1'b1;
         end
      end
      case (rq.req_type)
         RQ_READ, RQ_WRITE: begin
            touch_count++;
            open_kind = PEND_NONE;
            if (!found) begin
               idx = choose_victim(base);
               cache_stamp[idx] = touch_count;
               r.victim_writeback = (cache_state[idx] == ST_M || cache_state[idx] == ST_SM);
               cache_tag[idx] = tag;
               if (rq.req_type == RQ_WRITE) begin
                  cache_state[idx] = ST_M;
                  if (mode_dragon == MODE_MSI) r.bus_request = BUS_RDX;
                  else begin
                     r.bus_request = BUS_RD;
                     open_kind = PEND_WR_MISS;
                  end
               end else begin
                  r.bus_request = BUS_RD;
                  if (mode_dragon == MODE_MSI) cache_state[idx] = ST_S;
                  else begin
                     cache_state[idx] = ST_SC;
                     open_kind = PEND_RD_MISS;
                  end
               end
            end else begin
               cache_stamp[idx] = touch_count;
               if (rq.req_type == RQ_WRITE) begin
                  s = cache_state[idx];
                  if (mode_dragon == MODE_MSI) begin
                     // silent upgrade from S
                     if (s == ST_S) cache_state[idx] = ST_M;
                  end else begin
                     open_kind = PEND_WR_HIT;
                     if (s == ST_SC || s == ST_SM) r.bus_request = BUS_UPD;
                     else if (s == ST_E) cache_state[idx] = ST_M;
                  end
               end
            end
            r.new_state = cache_state[idx];
         end
         RQ_BUSRD, RQ_BUSRDX, RQ_BUSUPD: begin
            if (found) begin
               s = cache_state[idx];
               if (mode_dragon == MODE_MSI) begin
                  if (s == ST_M) begin
                     cache_state[idx] = ST_I;
                     r.snoop_flush = 1'b1;
                  end else if (s == ST_S) cache_state[idx] = ST_I;
               end else if (rq.req_type == RQ_BUSRD) begin
                  r.shared_copy = 1'b1;
                  if (s == ST_E) cache_state[idx] = ST_SC;
                  else if (s == ST_M) begin
                     cache_state[idx] = ST_SM;
                     r.snoop_flush = 1'b1;
                  end else if (s == ST_SM) r.snoop_flush = 1'b1;
               end else if (rq.req_type == RQ_BUSUPD) begin
                  r.shared_copy = 1'b1;
                  if (s == ST_SM) cache_state[idx] = ST_SC;
               end
               r.new_state = cache_state[idx];
            end
         end
         RQ_DONE: begin
            if (found) begin
               if (mode_dragon == MODE_DRAGON) begin
                  s = cache_state[idx];
                  if (open_kind == PEND_WR_MISS) begin
                     if (rq.copy_exist) begin
                        cache_state[idx] = ST_SM;
                        r.bus_request = BUS_UPD;
                     end else cache_state[idx] = ST_M;
                  end else if (open_kind == PEND_RD_MISS) begin
                     cache_state[idx] = rq.copy_exist ? ST_SC : ST_E;
                  end else if (open_kind == PEND_WR_HIT) begin
                     if (s == ST_E) cache_state[idx] = ST_M;
                     else if (s == ST_SC) cache_state[idx] = rq.copy_exist ? ST_SM : ST_M;
                     else if (s == ST_SM && !rq.copy_exist) cache_state[idx] = ST_M;
                  end
               end
               r.new_state = cache_state[idx];
            end
         end
         default: found = 1'b0;
      endcase
      r.hit = found;
      return r;
   endfunction

   // mostly no gap, sometimes a short one, now and then a long one
   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // send one beat and log its expected response at acceptance; valid stays
   // high after acceptance until a gap or a drain drops it
   task automatic send_beat(logic [2:0] kind, logic [31:0] addr, logic cp, logic gaps);
      req_item_type rq;
      int           idle;
      idle = gaps ? gap_length() : 0;
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      rq.req_type = kind;
      rq.address = addr;
      rq.copy_exist = cp;
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp.push_back(predict_coherence(rq));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_mode(logic m);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mode_dragon = m;
   endtask

   // address from a small tag pool over a few sets so lines collide and recur
   function automatic logic [31:0] pool_address();
      logic [31:0] a;
      a = $urandom();
      a[11:6] = 6'($urandom_range(0, 3));
      a[31:12] = 20'($urandom_range(0, 7));
      return a;
   endfunction

   task automatic test_extremes();
      set_mode(MODE_MSI);
      send_beat(RQ_READ, 32'h0000_0000, 1'b0, 1'b0);
      send_beat(RQ_WRITE, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_beat(RQ_READ, 32'hFFFF_FFC0, 1'b0, 1'b0);
      send_beat(RQ_WRITE, 32'h0000_003F, 1'b0, 1'b0);
      send_beat(RQ_BUSRD, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_beat(RQ_BUSRDX, 32'h0000_0000, 1'b1, 1'b0);
      send_beat(RQ_DONE, 32'h0000_0000, 1'b1, 1'b0);
      send_beat(3'd6, 32'hAAAA_5555, 1'b1, 1'b0);
      send_beat(3'd7, 32'h5555_AAAA, 1'b0, 1'b0);
   endtask

   // fill one set past its ways so LRU victims and writebacks appear
   task automatic test_msi_eviction();
      set_mode(MODE_MSI);
      for (int t = 0; t < 6; t++) send_beat(RQ_WRITE, {20'(t), 6'd5, 6'd0}, 1'b0, 1'b0);
      send_beat(RQ_READ, {20'd2, 6'd5, 6'd0}, 1'b0, 1'b0);
      send_beat(RQ_WRITE, {20'd2, 6'd5, 6'd0}, 1'b0, 1'b0);
      send_beat(RQ_BUSUPD, {20'd5, 6'd5, 6'd0}, 1'b0, 1'b0);
   endtask

   task automatic test_dragon_flows();
      set_mode(MODE_DRAGON);
      send_beat(RQ_READ, 32'h0000_1040, 1'b0, 1'b0);
      send_beat(RQ_DONE, 32'h0000_1040, 1'b0, 1'b0);
      send_beat(RQ_WRITE, 32'h0000_1040, 1'b0, 1'b0);
      send_beat(RQ_DONE, 32'h0000_1040, 1'b0, 1'b0);
      send_beat(RQ_BUSRD, 32'h0000_1040, 1'b0, 1'b0);
      send_beat(RQ_WRITE, 32'h0000_1040, 1'b0, 1'b0);
      send_beat(RQ_DONE, 32'h0000_1040, 1'b1, 1'b0);
      send_beat(RQ_BUSUPD, 32'h0000_1040, 1'b0, 1'b0);
      send_beat(RQ_BUSRDX, 32'h0000_1040, 1'b0, 1'b0);
      send_beat(RQ_WRITE, 32'h0000_2080, 1'b0, 1'b0);
      send_beat(RQ_DONE, 32'h0000_2080, 1'b1, 1'b0);
      send_beat(RQ_DONE, 32'h0000_3000, 1'b1, 1'b0);
   endtask

   // processor access, in Dragon mode usually followed by its completion, plus snoops and noise
   task automatic test_random_mix(logic m, int count);
      logic [31:0] a;
      int          pick;
      set_mode(m);
      stall_enable = 1'b1;
      for (int k = 0; k < count; k++) begin
         a = pool_address();
         pick = $urandom_range(0, 99);
         if (k % 100 > 80) begin
            send_beat(3'($urandom_range(0, 5)), a, 1'($urandom_range(0, 1)), 1'b0);
         end else if (pick < 55) begin
            send_beat(3'($urandom_range(0, 1)), a, 1'b0, 1'b1);
            if (m == MODE_DRAGON && $urandom_range(0, 9) < 8)
               send_beat(RQ_DONE, a, 1'($urandom_range(0, 1)), 1'b1);
         end else if (pick < 90) begin
            send_beat(3'($urandom_range(2, 4)), a, 1'($urandom_range(0, 1)), 1'b1);
         end else if (pick < 95) begin
            send_beat(RQ_DONE, a, 1'($urandom_range(0, 1)), 1'b1);
         end else begin
            send_beat(3'($urandom_range(0, 7)), $urandom(), 1'($urandom_range(0, 1)), 1'b1);
         end
      end
      stall_enable = 1'b0;
   endtask

   // hold stall for random stretches, with quiet phases where it stays low
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_enable && $urandom_range(0, 3) == 0)
            rsp_stall <= ($urandom_range(0, 9) == 0) ? 1'b1 : ($urandom_range(0, 1) == 1);
         else if (!stall_enable || $urandom_range(0, 1) == 0)
            rsp_stall <= 1'b0;
      end
   end

   // compare each response beat with the oldest expectation
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.bus_request !== want.bus_request) begin
               $display("%0t: bus_request expected %0d actual %0d", $time,
                        want.bus_request, rsp_data.bus_request);
               error_count++;
            end
            if (rsp_data.hit !== want.hit) begin
               $display("%0t: hit expected %0d actual %0d", $time, want.hit, rsp_data.hit);
               error_count++;
            end
            if (rsp_data.victim_writeback !== want.victim_writeback) begin
               $display("%0t: victim_writeback expected %0d actual %0d", $time,
                        want.victim_writeback, rsp_data.victim_writeback);
               error_count++;
            end
            if (rsp_data.snoop_flush !== want.snoop_flush) begin
               $display("%0t: snoop_flush expected %0d actual %0d", $time,
                        want.snoop_flush, rsp_data.snoop_flush);
               error_count++;
            end
            if (rsp_data.shared_copy !== want.shared_copy) begin
               $display("%0t: shared_copy expected %0d actual %0d", $time,
                        want.shared_copy, rsp_data.shared_copy);
               error_count++;
            end
            if (rsp_data.new_state !== want.new_state) begin
               $display("%0t: new_state expected %0d actual %0d", $time,
                        want.new_state, rsp_data.new_state);
               error_count++;
            end
         end
      end
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      stall_enable = 1'b0;
      touch_count = '0;
      open_kind = PEND_NONE;
      mode_dragon = MODE_MSI;
      for (int i = 0; i < NLINES; i++) begin
         cache_tag[i] = '0;
         cache_state[i] = ST_I;
         cache_stamp[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_msi_eviction();
      test_dragon_flows();
      test_random_mix(MODE_MSI, 350);
      test_random_mix(MODE_DRAGON, 300);
      test_random_mix(MODE_MSI, 150);
      test_random_mix(MODE_DRAGON, 150);
      drain();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
